// ----- sv/cfts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Case-folding text pattern search: shared types and constants
// Code-unit type, item and status codes, register indexes, the control
// bundle that drives the row of compare cells, and ASCII case folding.
// ----------------------------------------------------------------------------
package cfts_pkg;

  localparam int UNIT_W    = 16;
  localparam int LEN_CFG_W = 7;
  localparam int CFG_IDX_W = 2;

  typedef logic [UNIT_W-1:0] unit_t;

  typedef enum logic [1:0] {
    MODE_PATTERN = 2'd0,
    MODE_DOC     = 2'd1,
    MODE_END     = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_MATCH      = 2'd0,
    STATUS_END        = 2'd1,
    STATUS_START      = 2'd2,
    STATUS_NO_PATTERN = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH   = 2'd0,
    CFG_CASE_SENSITIVE   = 2'd1,
    CFG_SEARCH_BACKWARDS = 2'd2,
    CFG_CURSOR_OFFSET    = 2'd3
  } cfg_index_t;

  typedef enum logic {
    ITEM_DOC = 1'b0,
    ITEM_END = 1'b1
  } item_kind_t;

  // Control bundle broadcast to every compare cell.
  typedef struct packed {
    logic shift;    // a document unit enters the window chain
    logic load;     // a pattern unit is written at the load index
    logic capture;  // the compare result of the item in stage 1 is kept
    logic fold;     // ASCII upper case maps to lower case before compare
  } cell_ctrl_t;

  localparam unit_t FOLD_LOW   = 16'h0041;
  localparam unit_t FOLD_HIGH  = 16'h005A;
  localparam unit_t FOLD_DELTA = 16'd32;

  function automatic unit_t fold_unit(input unit_t u, input logic fold_en);
    unit_t r;
    r = u;
    if (fold_en && (u >= FOLD_LOW) && (u <= FOLD_HIGH)) begin
      r = u + FOLD_DELTA;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/cfts_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Compare cell
// Holds one window unit that moves to the next cell on every document beat,
// one pattern unit, and the registered compare of that pattern unit against
// the window unit aligned to it.
// ----------------------------------------------------------------------------
module cfts_cell #(
  parameter int MAX_PATTERN = 64,
  parameter int IDX         = 0
) (
  input  logic                               clk,
  input  cfts_pkg::cell_ctrl_t               ctrl,
  input  cfts_pkg::unit_t                    unit_in,
  input  cfts_pkg::unit_t                    pattern_in,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]   load_idx,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]   len,
  input  cfts_pkg::unit_t                    aligned,
  output cfts_pkg::unit_t                    window,
  output logic                               eq
);
  import cfts_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  unit_t pattern;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      window <= unit_in;
    end
    if (ctrl.load && (load_idx == LEN_W'(IDX))) begin
      pattern <= pattern_in;
    end
    // Cells past the pattern length always agree.
    if (ctrl.capture) begin
      eq <= (LEN_W'(IDX) >= len) ||
            (fold_unit(pattern, ctrl.fold) == fold_unit(aligned, ctrl.fold));
    end
  end

endmodule
`default_nettype wire

// ----- sv/cfts_align.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window alignment shifter
// Routes the window unit that belongs under pattern position i to cell i,
// that is the (len-1-i)-th most recent document unit, with a log-depth
// shifter over the reversed window.
// ----------------------------------------------------------------------------
module cfts_align #(
  parameter int MAX_PATTERN = 64
) (
  input  cfts_pkg::unit_t                  window  [MAX_PATTERN],
  input  logic [$clog2(MAX_PATTERN+1)-1:0] len,
  output cfts_pkg::unit_t                  aligned [MAX_PATTERN]
);
  import cfts_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0] shift_amt;
  unit_t            stage [LEN_W+1][MAX_PATTERN];

  assign shift_amt = LEN_W'(MAX_PATTERN) - len;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      stage[0][j] = window[MAX_PATTERN-1-j];
    end
    for (int lvl = 0; lvl < LEN_W; lvl++) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (!shift_amt[lvl]) begin
          stage[lvl+1][i] = stage[lvl][i];
        end else if (i + (1 << lvl) < MAX_PATTERN) begin
          stage[lvl+1][i] = stage[lvl][i + (1 << lvl)];
        end else begin
          stage[lvl+1][i] = '0;
        end
      end
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      aligned[i] = stage[LEN_W][i];
    end
  end

endmodule
`default_nettype wire

// ----- sv/case_folding_text_pattern_search_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Case-folding text pattern search, top level
// Streams UTF-16 code units past a stored pattern of up to MAX_PATTERN units
// and reports the first (forward) or last allowed (backward) match.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock and keeps that rate as long as
// results are taken. A result beat goes from the edge that accepts the beat
// causing it through the second-step, third-step and output registers to
// the result port. Beats run through three registered steps. On
// acceptance a pattern unit is written into its cell, or a document unit
// enters cell 0 of the window chain while every cell hands its unit to the
// next one, and the counters move. In the second step the alignment shifter
// routes the window unit that sits under each pattern position to its cell,
// and every cell registers its folded compare; this shifter and the per-cell
// compare set the clock rate. In the third step the cell results are ANDed,
// the match start is turned into a document offset, and the search state
// (first match found, best backward match) decides the result beat, which
// waits in the output register. item_stall rises only when both inner steps
// are full and a result is held by result_stall, so up to two further
// document or end beats are taken while a result waits; pattern beats and
// unused beats finish at acceptance and occupy no step. Registers may be
// written while the block is idle and each beat uses the values current at
// its acceptance. Pattern and window cells are not cleared by reset and need
// no clearing pass; a pattern length longer than the loaded pattern compares
// against unwritten cells. Pattern units past MAX_PATTERN are dropped, and a
// length above MAX_PATTERN is taken as MAX_PATTERN.
// ----------------------------------------------------------------------------
module case_folding_text_pattern_search_top #(
  parameter int MAX_PATTERN = 64,
  parameter int OFFSET_BITS = 40
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [cfts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [OFFSET_BITS-1:0]           cfg_wdata,
  // Item channel.
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [1:0]                       mode,
  input  logic [cfts_pkg::UNIT_W-1:0]      code_unit,
  // Result channel.
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [1:0]                       status,
  output logic [OFFSET_BITS-1:0]           found_offset
);
  import cfts_pkg::*;

  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int SEEN_W = OFFSET_BITS + 1;
  localparam int CMP_W  = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;

  // Configuration registers.
  logic [LEN_CFG_W-1:0]   pattern_length;
  logic                   case_sensitive;
  logic                   search_backwards;
  logic [OFFSET_BITS-1:0] cursor_offset;

  // Acceptance-step state.
  logic [LEN_W-1:0]  load_idx;
  logic [SEEN_W-1:0] units_seen;

  // Second step.
  logic                   v1;
  item_kind_t             s1_kind;
  logic [SEEN_W-1:0]      s1_seen;
  logic [LEN_W-1:0]       s1_len;
  logic                   s1_fold;
  logic                   s1_back;
  logic [OFFSET_BITS-1:0] s1_cursor;

  // Third step.
  logic                   v2;
  item_kind_t             s2_kind;
  logic                   s2_len_zero;
  logic                   s2_back;
  logic [OFFSET_BITS-1:0] s2_cursor;
  logic                   s2_full;
  logic [SEEN_W-1:0]      s2_start;

  // Search state, updated as beats leave the third step.
  logic                   done;
  logic                   done_next;
  logic                   best_valid;
  logic                   best_valid_next;
  logic [OFFSET_BITS-1:0] best_off;
  logic [OFFSET_BITS-1:0] best_off_next;

  logic [CMP_W-1:0]       len_wide;
  logic [LEN_W-1:0]       len_eff;
  logic                   accept;
  logic                   doc_take;
  logic                   pat_take;
  logic                   end_take;
  logic                   can_out;
  logic                   free2;
  logic                   adv1;
  logic                   adv2;
  logic                   s1_full;
  logic [SEEN_W-1:0]      s1_start;
  logic                   all_eq;
  logic                   hit;
  logic                   in_range;
  logic [OFFSET_BITS-1:0] fwd_off;
  logic                   res_fire;
  status_t                res_status;
  logic [OFFSET_BITS-1:0] res_off;

  cell_ctrl_t             cell_ctrl;
  unit_t                  chain_in [MAX_PATTERN];
  unit_t                  window   [MAX_PATTERN];
  unit_t                  aligned  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq_vec;

  // --------------------------------------------------------------------------
  // Configuration.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length   <= '0;
      case_sensitive   <= 1'b1;
      search_backwards <= 1'b0;
      cursor_offset    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PATTERN_LENGTH:   pattern_length   <= cfg_wdata[LEN_CFG_W-1:0];
        CFG_CASE_SENSITIVE:   case_sensitive   <= cfg_wdata[0];
        CFG_SEARCH_BACKWARDS: search_backwards <= cfg_wdata[0];
        CFG_CURSOR_OFFSET:    cursor_offset    <= cfg_wdata;
      endcase
    end
  end

  // A length above the cell count saturates to the cell count.
  assign len_wide = CMP_W'(pattern_length);
  assign len_eff  = (len_wide > CMP_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                     : LEN_W'(len_wide);

  // --------------------------------------------------------------------------
  // Handshake. Every step moves when the one after it can take its beat.
  // --------------------------------------------------------------------------
  assign can_out    = !result_valid || !result_stall;
  assign adv2       = v2 && can_out;
  assign free2      = !v2 || can_out;
  assign adv1       = v1 && free2;
  assign item_stall = v1 && !free2;
  assign accept     = item_valid && !item_stall;

  // A document unit is dropped once the unit count has saturated.
  assign doc_take = accept && (mode_t'(mode) == MODE_DOC) && (units_seen != '1);
  assign pat_take = accept && (mode_t'(mode) == MODE_PATTERN) &&
                    (load_idx < LEN_W'(MAX_PATTERN));
  assign end_take = accept && (mode_t'(mode) == MODE_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_idx   <= '0;
      units_seen <= '0;
    end else if (end_take) begin
      load_idx   <= '0;
      units_seen <= '0;
    end else begin
      if (pat_take) begin
        load_idx <= load_idx + LEN_W'(1);
      end
      if (doc_take) begin
        units_seen <= units_seen + SEEN_W'(1);
      end
    end
  end

  // Document and end beats travel on; pattern beats finish in the cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!item_stall) begin
      v1 <= doc_take || end_take;
    end
  end

  always_ff @(posedge clk) begin
    if (doc_take || end_take) begin
      s1_kind   <= doc_take ? ITEM_DOC : ITEM_END;
      s1_seen   <= units_seen + SEEN_W'(1);
      s1_len    <= len_eff;
      s1_fold   <= !case_sensitive;
      s1_back   <= search_backwards;
      s1_cursor <= cursor_offset;
    end
  end

  // --------------------------------------------------------------------------
  // Row of compare cells with the alignment shifter.
  // --------------------------------------------------------------------------
  assign cell_ctrl.shift   = doc_take;
  assign cell_ctrl.load    = pat_take;
  assign cell_ctrl.capture = adv1;
  assign cell_ctrl.fold    = s1_fold;

  for (genvar c = 0; c < MAX_PATTERN; c++) begin : g_cell
    if (c == 0) begin : g_head
      assign chain_in[c] = code_unit;
    end else begin : g_link
      assign chain_in[c] = window[c-1];
    end

    cfts_cell #(
      .MAX_PATTERN (MAX_PATTERN),
      .IDX         (c)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .unit_in    (chain_in[c]),
      .pattern_in (code_unit),
      .load_idx   (load_idx),
      .len        (s1_len),
      .aligned    (aligned[c]),
      .window     (window[c]),
      .eq         (eq_vec[c])
    );
  end

  cfts_align #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_align (
    .window  (window),
    .len     (s1_len),
    .aligned (aligned)
  );

  // The window is full once at least len units have arrived in this search.
  assign s1_full  = (s1_len != '0) && (SEEN_W'(s1_len) <= s1_seen);
  assign s1_start = s1_seen - SEEN_W'(s1_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (free2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_kind     <= s1_kind;
      s2_len_zero <= (s1_len == '0);
      s2_back     <= s1_back;
      s2_cursor   <= s1_cursor;
      s2_full     <= s1_full;
      s2_start    <= s1_start;
    end
  end

  // --------------------------------------------------------------------------
  // Decision step.
  // --------------------------------------------------------------------------
  assign all_eq   = &eq_vec;
  assign hit      = s2_full && all_eq && !done;
  assign fwd_off  = s2_cursor + s2_start[OFFSET_BITS-1:0];
  assign in_range = (s2_start <= SEEN_W'(s2_cursor));

  always_comb begin
    res_fire        = 1'b0;
    res_status      = STATUS_MATCH;
    res_off         = '0;
    done_next       = done;
    best_valid_next = best_valid;
    best_off_next   = best_off;
    if (adv2) begin
      unique case (s2_kind)
        ITEM_DOC: begin
          if (hit && !s2_back) begin
            // First forward match: report it and ignore the rest.
            res_fire        = 1'b1;
            res_off         = fwd_off;
            done_next       = 1'b1;
            best_valid_next = 1'b1;
            best_off_next   = fwd_off;
          end else if (hit && in_range) begin
            best_valid_next = 1'b1;
            best_off_next   = s2_start[OFFSET_BITS-1:0];
          end
        end
        ITEM_END: begin
          if (s2_len_zero) begin
            res_fire   = 1'b1;
            res_status = STATUS_NO_PATTERN;
          end else if (!s2_back) begin
            res_fire   = !done;
            res_status = STATUS_END;
          end else if (best_valid) begin
            res_fire   = 1'b1;
            res_off    = best_off;
          end else begin
            res_fire   = 1'b1;
            res_status = STATUS_START;
          end
          done_next       = 1'b0;
          best_valid_next = 1'b0;
          best_off_next   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      best_valid <= 1'b0;
      best_off   <= '0;
    end else begin
      done       <= done_next;
      best_valid <= best_valid_next;
      best_off   <= best_off_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (can_out) begin
      result_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (can_out && res_fire) begin
      status       <= res_status;
      found_offset <= res_off;
    end
  end

endmodule
`default_nettype wire

// ----- sv/cfts_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker for the case-folding text pattern search
// Watches the top-level ports and flags result beats or stalls that the
// block's pipeline cannot legally produce.
// ----------------------------------------------------------------------------
module cfts_checker #(
  parameter int OFFSET_BITS = 40
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_stall,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic [1:0]                     status,
  input logic [OFFSET_BITS-1:0]         found_offset
);
  import cfts_pkg::*;

  // A held result keeps its payload until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(status) && $stable(found_offset))
    else $error("result beat changed while stalled");

  // Only match results carry an offset.
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != STATUS_MATCH) |-> (found_offset == '0))
    else $error("non-match result carries a nonzero offset");

  // The input side is held back only by a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("item_stall raised without result backpressure");

  // No result is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat present right after reset");

endmodule

bind case_folding_text_pattern_search_top cfts_checker #(
  .OFFSET_BITS (OFFSET_BITS)
) u_cfts_checker (.*);
`default_nettype wire
